### rtl/core/assert_macros.svh
// Assertion macros shared by the frequency planner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/core/csdp_pkg.sv
// Package for the clock synthesiser divider planner: constants, types, states.
package csdp_pkg;

    localparam int FREQ_W    = 28;
    localparam int CHAN_W    = 2;
    localparam int XTAL_W    = 26;
    localparam int MULT_W    = 7;
    localparam int NUM_W     = 20;
    localparam int DIV_W     = 11;
    localparam int CODE_W    = 3;
    localparam int PLL_W     = 31;
    localparam int SHORT_W   = 30;
    localparam int DVD_W     = 48;
    localparam int DVS_W     = 28;
    localparam int PAD_W     = DVD_W - SHORT_W;
    localparam int CNT_W     = $clog2(DVD_W + 1);
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 2'd2;
    localparam logic [CHAN_W-1:0]  CHAN_PLL_B  = 2'd2;
    localparam logic [FREQ_W-1:0]  FREQ_MIN    = 28'd8000;
    localparam logic [FREQ_W-1:0]  FREQ_MAX    = 28'd150000000;
    localparam logic [FREQ_W-1:0]  MS_FLOOR    = 28'd500000;
    localparam logic [CODE_W-1:0]  RDIV_CODE_MAX = 3'd7;
    localparam logic [SHORT_W-1:0] PLL_TARGET  = 30'd800000000;
    localparam logic [SHORT_W-1:0] PLL_LOW     = 30'd600000000;
    localparam logic [SHORT_W-1:0] PLL_HIGH    = 30'd900000000;
    localparam logic [DIV_W-1:0]   DIV_MIN     = 11'd8;
    localparam logic [DIV_W-1:0]   DIV_MAX     = 11'd900;
    localparam logic [NUM_W-1:0]   FRAC_DENOM  = 20'd1048575;
    localparam logic [MULT_W-1:0]  MULT_MAX    = 7'd127;
    localparam logic [XTAL_W-1:0]  XTAL_RESET  = 26'd25000000;

    localparam logic [0:0]         REG_CRYSTAL = 1'b0;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  nbits;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
        logic [DVS_W-1:0]  remainder;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_TGT,
        ST_WAIT_TGT,
        ST_MUL,
        ST_CHECK,
        ST_WAIT_ADJ,
        ST_MUL_ADJ,
        ST_DIV_PLL,
        ST_WAIT_PLL,
        ST_DIV_NUM,
        ST_WAIT_NUM,
        ST_OUT
    } t_state;

endpackage

### rtl/core/clock_synth_divider_plan.sv
// Top level of the clock synthesiser divider planner: sequencer, datapath, APB register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  request  | in        | i_valid / o_ready  | i_output_channel, i_frequency_hz
//  result   | out       | o_valid / i_ready  | o_status, o_pll_select, o_pll_mult,
//           |           |                    | o_pll_numerator, o_ms_divider, o_rdiv_code
//  config   | in        | psel/penable/pwrite| paddr, pwdata, prdata, pready (crystal_hz)
//
// Full plan from acceptance to o_valid: R doublings in ST_SCALE (up to seven), then
// divider passes for target, optional band correction and crystal, then a pass for the
// fraction. Saturated multiplier skips the last pass, zero crystal the last two. A rejected
// request goes from idle straight to ST_OUT.
// One request in flight, o_ready only in idle; a result waits in the output register while
// the next request runs, which holds in ST_OUT until it drains. Sync active-low reset.
`include "assert_macros.svh"

module clock_synth_divider_plan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [csdp_pkg::CHAN_W-1:0]    i_output_channel,
    input  logic [csdp_pkg::FREQ_W-1:0]    i_frequency_hz,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_status,
    output logic                           o_pll_select,
    output logic [csdp_pkg::MULT_W-1:0]    o_pll_mult,
    output logic [csdp_pkg::NUM_W-1:0]     o_pll_numerator,
    output logic [csdp_pkg::DIV_W-1:0]     o_ms_divider,
    output logic [csdp_pkg::CODE_W-1:0]    o_rdiv_code,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [csdp_pkg::APB_AW-1:0]    paddr,
    input  logic [csdp_pkg::APB_DW-1:0]    pwdata,
    output logic [csdp_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    csdp_pkg::t_state                 r_state, n_state;
    logic [csdp_pkg::XTAL_W-1:0]      r_crystal;
    logic                             r_bad;
    logic                             r_pllb;
    logic [csdp_pkg::FREQ_W-1:0]      r_fms;
    logic [csdp_pkg::CODE_W-1:0]      r_code;
    logic [csdp_pkg::DIV_W-1:0]       r_div;
    logic [csdp_pkg::PLL_W-1:0]       r_pll;
    logic [csdp_pkg::MULT_W-1:0]      r_mult;
    logic [csdp_pkg::NUM_W-1:0]       r_num;
    logic                             r_ovalid;

    csdp_pkg::t_div_req               w_req;
    csdp_pkg::t_div_rsp               w_rsp;
    logic                             w_bad;
    logic                             w_scale;
    logic                             w_low;
    logic                             w_high;
    logic                             w_xtal_zero;
    logic                             w_mult_ovf;
    logic                             w_load_out;
    logic [csdp_pkg::SHORT_W-1:0]     w_q30;
    logic [csdp_pkg::DIV_W-1:0]       w_clamp;
    logic [csdp_pkg::FREQ_W+csdp_pkg::DIV_W-1:0] w_prod;
    logic [csdp_pkg::DVD_W-1:0]       w_num_dvd;
    logic [csdp_pkg::XTAL_W-1:0]      w_rem;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == csdp_pkg::REG_CRYSTAL)
                    ? {{(csdp_pkg::APB_DW-csdp_pkg::XTAL_W){1'b0}}, r_crystal} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal <= csdp_pkg::XTAL_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == csdp_pkg::REG_CRYSTAL) begin
            r_crystal <= pwdata[csdp_pkg::XTAL_W-1:0];
        end
    end

    assign w_bad = (i_output_channel > csdp_pkg::CHAN_MAX)
                || (i_frequency_hz < csdp_pkg::FREQ_MIN)
                || (i_frequency_hz > csdp_pkg::FREQ_MAX);

    assign w_scale     = (r_fms < csdp_pkg::MS_FLOOR) && (r_code < csdp_pkg::RDIV_CODE_MAX);
    assign w_low       = r_pll < csdp_pkg::PLL_W'(csdp_pkg::PLL_LOW);
    assign w_high      = r_pll > csdp_pkg::PLL_W'(csdp_pkg::PLL_HIGH);
    assign w_xtal_zero = (r_crystal == '0);
    assign w_q30       = w_rsp.quotient[csdp_pkg::SHORT_W-1:0];
    assign w_mult_ovf  = w_q30 > csdp_pkg::SHORT_W'(csdp_pkg::MULT_MAX);
    assign w_prod      = (csdp_pkg::FREQ_W+csdp_pkg::DIV_W)'(r_fms)
                       * (csdp_pkg::FREQ_W+csdp_pkg::DIV_W)'(r_div);
    assign w_rem       = w_rsp.remainder[csdp_pkg::XTAL_W-1:0];
    // 2*rem*(2^20-1) + crystal
    assign w_num_dvd   = csdp_pkg::DVD_W'({w_rem, 21'd0})
                       - csdp_pkg::DVD_W'({w_rem, 1'b0})
                       + csdp_pkg::DVD_W'(r_crystal);

    always_comb begin
        priority if (w_q30 < csdp_pkg::SHORT_W'(csdp_pkg::DIV_MIN)) begin
            w_clamp = csdp_pkg::DIV_MIN;
        end else if (w_q30 > csdp_pkg::SHORT_W'(csdp_pkg::DIV_MAX)) begin
            w_clamp = csdp_pkg::DIV_MAX;
        end else begin
            w_clamp = w_q30[csdp_pkg::DIV_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csdp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = w_bad ? csdp_pkg::ST_OUT : csdp_pkg::ST_SCALE;
                end
            end
            csdp_pkg::ST_SCALE: begin
                if (!w_scale) begin
                    n_state = csdp_pkg::ST_DIV_TGT;
                end
            end
            csdp_pkg::ST_DIV_TGT:  n_state = csdp_pkg::ST_WAIT_TGT;
            csdp_pkg::ST_WAIT_TGT: begin
                if (w_rsp.done) begin
                    n_state = csdp_pkg::ST_MUL;
                end
            end
            csdp_pkg::ST_MUL:      n_state = csdp_pkg::ST_CHECK;
            csdp_pkg::ST_CHECK: begin
                n_state = (w_low || w_high) ? csdp_pkg::ST_WAIT_ADJ : csdp_pkg::ST_DIV_PLL;
            end
            csdp_pkg::ST_WAIT_ADJ: begin
                if (w_rsp.done) begin
                    n_state = csdp_pkg::ST_MUL_ADJ;
                end
            end
            csdp_pkg::ST_MUL_ADJ:  n_state = csdp_pkg::ST_DIV_PLL;
            csdp_pkg::ST_DIV_PLL: begin
                n_state = w_xtal_zero ? csdp_pkg::ST_OUT : csdp_pkg::ST_WAIT_PLL;
            end
            csdp_pkg::ST_WAIT_PLL: begin
                if (w_rsp.done) begin
                    n_state = w_mult_ovf ? csdp_pkg::ST_OUT : csdp_pkg::ST_DIV_NUM;
                end
            end
            csdp_pkg::ST_DIV_NUM:  n_state = csdp_pkg::ST_WAIT_NUM;
            csdp_pkg::ST_WAIT_NUM: begin
                if (w_rsp.done) begin
                    n_state = csdp_pkg::ST_OUT;
                end
            end
            csdp_pkg::ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_state = csdp_pkg::ST_IDLE;
                end
            end
            default: n_state = csdp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready        = 1'b0;
        w_load_out     = 1'b0;
        w_req.start    = 1'b0;
        w_req.nbits    = csdp_pkg::CNT_W'(csdp_pkg::SHORT_W);
        w_req.dividend = {csdp_pkg::PLL_TARGET, {csdp_pkg::PAD_W{1'b0}}};
        w_req.divisor  = r_fms;
        unique case (r_state)
            csdp_pkg::ST_IDLE: o_ready = 1'b1;
            csdp_pkg::ST_DIV_TGT: w_req.start = 1'b1;
            csdp_pkg::ST_CHECK: begin
                w_req.start = w_low || w_high;
                if (w_low) begin
                    // ceiling division
                    w_req.dividend = {csdp_pkg::PLL_LOW
                                      + csdp_pkg::SHORT_W'(r_fms)
                                      - csdp_pkg::SHORT_W'(1),
                                      {csdp_pkg::PAD_W{1'b0}}};
                end else begin
                    w_req.dividend = {csdp_pkg::PLL_HIGH, {csdp_pkg::PAD_W{1'b0}}};
                end
            end
            csdp_pkg::ST_DIV_PLL: begin
                w_req.start    = !w_xtal_zero;
                w_req.dividend = {r_pll[csdp_pkg::SHORT_W-1:0], {csdp_pkg::PAD_W{1'b0}}};
                w_req.divisor  = csdp_pkg::DVS_W'(r_crystal);
            end
            csdp_pkg::ST_DIV_NUM: begin
                w_req.start    = 1'b1;
                w_req.nbits    = csdp_pkg::CNT_W'(csdp_pkg::DVD_W);
                w_req.dividend = w_num_dvd;
                w_req.divisor  = csdp_pkg::DVS_W'({r_crystal, 1'b0});
            end
            csdp_pkg::ST_OUT: w_load_out = !r_ovalid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= csdp_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            csdp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    r_bad  <= w_bad;
                    r_pllb <= (i_output_channel == csdp_pkg::CHAN_PLL_B);
                    r_fms  <= i_frequency_hz;
                    r_code <= '0;
                end
            end
            csdp_pkg::ST_SCALE: begin
                if (w_scale) begin
                    r_fms  <= {r_fms[csdp_pkg::FREQ_W-2:0], 1'b0};
                    r_code <= r_code + 1'b1;
                end
            end
            csdp_pkg::ST_WAIT_TGT: begin
                if (w_rsp.done) begin
                    r_div <= w_clamp;
                end
            end
            csdp_pkg::ST_MUL, csdp_pkg::ST_MUL_ADJ: begin
                r_pll <= w_prod[csdp_pkg::PLL_W-1:0];
            end
            csdp_pkg::ST_WAIT_ADJ: begin
                if (w_rsp.done) begin
                    r_div <= w_q30[csdp_pkg::DIV_W-1:0];
                end
            end
            csdp_pkg::ST_DIV_PLL: begin
                if (w_xtal_zero) begin
                    r_mult <= csdp_pkg::MULT_MAX;
                    r_num  <= csdp_pkg::FRAC_DENOM;
                end
            end
            csdp_pkg::ST_WAIT_PLL: begin
                if (w_rsp.done) begin
                    if (w_mult_ovf) begin
                        r_mult <= csdp_pkg::MULT_MAX;
                        r_num  <= csdp_pkg::FRAC_DENOM;
                    end else begin
                        r_mult <= w_q30[csdp_pkg::MULT_W-1:0];
                    end
                end
            end
            csdp_pkg::ST_WAIT_NUM: begin
                if (w_rsp.done) begin
                    r_num <= w_rsp.quotient[csdp_pkg::NUM_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_status        <= r_bad;
            o_pll_select    <= r_bad ? 1'b0 : r_pllb;
            o_pll_mult      <= r_bad ? '0 : r_mult;
            o_pll_numerator <= r_bad ? '0 : r_num;
            o_ms_divider    <= r_bad ? '0 : r_div;
            o_rdiv_code     <= r_bad ? '0 : r_code;
        end
    end

    assign o_valid = r_ovalid;

    csdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    `ASSERT_CLK(a_done_in_wait, i_clk, i_rst_n, w_rsp.done |-> (r_state == csdp_pkg::ST_WAIT_TGT || r_state == csdp_pkg::ST_WAIT_ADJ || r_state == csdp_pkg::ST_WAIT_PLL || r_state == csdp_pkg::ST_WAIT_NUM), "divider finished outside a wait state")
    `ASSERT_CLK(a_reject_zero, i_clk, i_rst_n, (o_valid && o_status) |-> (!o_pll_select && o_pll_mult == '0 && o_pll_numerator == '0 && o_ms_divider == '0 && o_rdiv_code == '0), "rejected request carries a plan")
    `ASSERT_CLK(a_div_range, i_clk, i_rst_n, (o_valid && !o_status) |-> (o_ms_divider >= 11'd6 && o_ms_divider <= 11'd1200), "multisynth divider out of range")

endmodule

### rtl/core/csdp_div.sv
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
`include "assert_macros.svh"

module csdp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csdp_pkg::t_div_req i_req,
    output csdp_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic [csdp_pkg::CNT_W-1:0]    r_cnt;
    logic [csdp_pkg::DVS_W-1:0]    r_rem;
    logic [csdp_pkg::DVD_W-1:0]    r_q;
    logic [csdp_pkg::DVS_W-1:0]    r_dvs;
    logic [csdp_pkg::DVS_W:0]      w_shift;
    logic [csdp_pkg::DVS_W:0]      w_diff;
    logic                          w_step;

    assign w_step  = r_busy && (r_cnt != '0);
    assign w_shift = {r_rem, r_q[csdp_pkg::DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.nbits;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (w_step) begin
            if (!w_diff[csdp_pkg::DVS_W]) begin
                r_rem <= w_diff[csdp_pkg::DVS_W-1:0];
                r_q   <= {r_q[csdp_pkg::DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[csdp_pkg::DVS_W-1:0];
                r_q   <= {r_q[csdp_pkg::DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_busy && (r_cnt == '0);
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_req.start && r_busy, "divider restarted while busy")
    `ASSERT_CLK(a_done_pulse, i_clk, i_rst_n, o_rsp.done |=> !o_rsp.done, "divider done held")

endmodule
